// ----- rtl/gfls_pkg.sv -----
package gfls_pkg;

  localparam int NUM_IDS    = 1024;
  localparam int NUM_GROUPS = 1024;

  // fixed field widths of the request and result
  localparam int ID_W     = 11;
  localparam int GROUP_W  = 10;
  localparam int STATUS_W = 2;

  // internal index and count widths
  localparam int IX_W    = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int GR_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int DEPTH_W = $clog2(NUM_IDS + 1);
  localparam int FILL_W  = $clog2(NUM_GROUPS + 1);

  // record widths: id entry {present, link}, group entry {active, top, depth}
  localparam int ID_REC_W  = 1 + IX_W;
  localparam int GRP_REC_W = 1 + IX_W + DEPTH_W;

  localparam int CLR_N = (NUM_IDS > NUM_GROUPS) ? NUM_IDS : NUM_GROUPS;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 2'd0,
    ST_IGNORED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH_EVAL,
    S_POP_GRP,
    S_POP_TOP,
    S_POP_LINK
  } state_t;

  typedef struct packed {
    logic             present;
    logic [IX_W-1:0]  link;
  } id_rec_t;

  typedef struct packed {
    logic               active;
    logic [IX_W-1:0]    top;
    logic [DEPTH_W-1:0] depth;
  } grp_rec_t;

endpackage

// ----- rtl/gfls_if.sv -----
interface gfls_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [gfls_pkg::ID_W-1:0]    item_id;
  logic [gfls_pkg::GROUP_W-1:0] item_group;

  modport source (output valid, req_type, item_id, item_group, input ready);
  modport sink   (input valid, req_type, item_id, item_group, output ready);
endinterface

interface gfls_res_if;
  logic                          valid;
  logic                          ready;
  logic [gfls_pkg::STATUS_W-1:0] status;
  logic [gfls_pkg::ID_W-1:0]     popped_id;

  modport source (output valid, status, popped_id, input ready);
  modport sink   (input valid, status, popped_id, output ready);
endinterface

// ----- rtl/gfls_ram.sv -----
module gfls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grouped_fifo_of_lifo_stacks.sv -----
// Group-aware queue: groups leave in arrival order, ids within a group leave last in,
// first out. One request is handled at a time, one result per request. A push reads the
// group and id memories and then writes them back; a pop steps through dependent
// registered reads of the ring, group and id memories followed by the write-back; a pop
// on an empty queue is answered straight from the idle state. After reset a clearing pass
// over max(NUM_IDS, NUM_GROUPS) entries (1024 as built) wipes the present and active flags,
// during which no request is taken. A new request is taken while the previous result
// is being handed over.
module grouped_fifo_of_lifo_stacks (
  input  logic            clk,
  input  logic            rst,
  gfls_req_if.sink        request,
  gfls_res_if.source      result
);

  gfls_pkg::state_t state, state_next;

  logic [gfls_pkg::CLR_W-1:0]  clr_cnt;
  logic                        push_ok;
  logic [gfls_pkg::IX_W-1:0]   ix;
  logic [gfls_pkg::GR_W-1:0]   grp;
  logic [gfls_pkg::GR_W-1:0]   ring_head, ring_head_next;
  logic [gfls_pkg::GR_W-1:0]   ring_tail, ring_tail_next;
  logic [gfls_pkg::FILL_W-1:0] ring_fill, ring_fill_next;
  logic [gfls_pkg::GR_W-1:0]   pop_grp;
  logic [gfls_pkg::IX_W-1:0]   pop_top;
  logic [gfls_pkg::DEPTH_W-1:0] pop_depth;

  logic                        res_valid;
  logic [gfls_pkg::STATUS_W-1:0] res_status;
  logic [gfls_pkg::ID_W-1:0]   res_id;
  logic                        res_load;
  gfls_pkg::status_t           res_status_next;
  logic [gfls_pkg::ID_W-1:0]   res_id_next;

  logic                        accept;
  logic                        id_ok, grp_ok;
  logic [gfls_pkg::ID_W-1:0]   id_dec;

  // memory ports
  logic                          id_we;
  logic [gfls_pkg::IX_W-1:0]     id_waddr, id_raddr;
  gfls_pkg::id_rec_t             id_wdata, id_rdata;
  logic                          grp_we;
  logic [gfls_pkg::GR_W-1:0]     grp_waddr, grp_raddr;
  gfls_pkg::grp_rec_t            grp_wdata, grp_rdata;
  logic                          ring_we;
  logic [gfls_pkg::GR_W-1:0]     ring_wdata, ring_rdata;

  gfls_ram #(.WIDTH(gfls_pkg::ID_REC_W), .DEPTH(gfls_pkg::NUM_IDS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  gfls_ram #(.WIDTH(gfls_pkg::GRP_REC_W), .DEPTH(gfls_pkg::NUM_GROUPS)) u_grp_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (grp_waddr),
    .wdata (grp_wdata),
    .raddr (grp_raddr),
    .rdata (grp_rdata)
  );

  gfls_ram #(.WIDTH(gfls_pkg::GR_W), .DEPTH(gfls_pkg::NUM_GROUPS)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_tail),
    .wdata (ring_wdata),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  assign request.ready    = (state == gfls_pkg::S_IDLE) && (!res_valid || result.ready);
  assign accept           = request.valid && request.ready;
  assign result.valid     = res_valid;
  assign result.status    = res_status;
  assign result.popped_id = res_id;

  assign id_ok  = (request.item_id != '0) && (32'(request.item_id) <= gfls_pkg::NUM_IDS);
  assign grp_ok = 32'(request.item_group) < gfls_pkg::NUM_GROUPS;
  assign id_dec = request.item_id - gfls_pkg::ID_W'(1);

  function automatic logic [gfls_pkg::GR_W-1:0] ring_step(
    input logic [gfls_pkg::GR_W-1:0] pos
  );
    return (pos == gfls_pkg::GR_W'(gfls_pkg::NUM_GROUPS - 1)) ? '0
                                                             : pos + gfls_pkg::GR_W'(1);
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gfls_pkg::S_CLEAR: begin
        if (clr_cnt == gfls_pkg::CLR_W'(gfls_pkg::CLR_N - 1)) begin
          state_next = gfls_pkg::S_IDLE;
        end
      end
      gfls_pkg::S_IDLE: begin
        if (accept) begin
          if (request.req_type == gfls_pkg::REQ_PUSH) begin
            state_next = gfls_pkg::S_PUSH_EVAL;
          end else if (ring_fill != '0) begin
            state_next = gfls_pkg::S_POP_GRP;
          end
        end
      end
      gfls_pkg::S_PUSH_EVAL: state_next = gfls_pkg::S_IDLE;
      gfls_pkg::S_POP_GRP:   state_next = gfls_pkg::S_POP_TOP;
      gfls_pkg::S_POP_TOP:   state_next = gfls_pkg::S_POP_LINK;
      gfls_pkg::S_POP_LINK:  state_next = gfls_pkg::S_IDLE;
      default:               state_next = gfls_pkg::S_CLEAR;
    endcase
  end

  // memory controls, ring pointers and result
  always_comb begin
    id_we           = 1'b0;
    id_waddr        = ix;
    id_wdata        = '0;
    id_raddr        = id_dec[gfls_pkg::IX_W-1:0];
    grp_we          = 1'b0;
    grp_waddr       = grp;
    grp_wdata       = '0;
    grp_raddr       = request.item_group[gfls_pkg::GR_W-1:0];
    ring_we         = 1'b0;
    ring_wdata      = grp;
    ring_head_next  = ring_head;
    ring_tail_next  = ring_tail;
    ring_fill_next  = ring_fill;
    res_load        = 1'b0;
    res_status_next = gfls_pkg::ST_IGNORED;
    res_id_next     = '0;
    case (state)
      gfls_pkg::S_CLEAR: begin
        id_we     = 32'(clr_cnt) < gfls_pkg::NUM_IDS;
        id_waddr  = clr_cnt[gfls_pkg::IX_W-1:0];
        grp_we    = 32'(clr_cnt) < gfls_pkg::NUM_GROUPS;
        grp_waddr = clr_cnt[gfls_pkg::GR_W-1:0];
      end
      gfls_pkg::S_IDLE: begin
        if (accept && request.req_type == gfls_pkg::REQ_POP && ring_fill == '0) begin
          res_load        = 1'b1;
          res_status_next = gfls_pkg::ST_EMPTY;
        end
      end
      gfls_pkg::S_PUSH_EVAL: begin
        res_load = 1'b1;
        if (push_ok && !id_rdata.present) begin
          res_status_next  = gfls_pkg::ST_PUSHED;
          id_we            = 1'b1;
          id_wdata.present = 1'b1;
          id_wdata.link    = grp_rdata.active ? grp_rdata.top : '0;
          grp_we           = 1'b1;
          grp_wdata.active = 1'b1;
          grp_wdata.top    = ix;
          if (grp_rdata.active) begin
            grp_wdata.depth = grp_rdata.depth + gfls_pkg::DEPTH_W'(1);
          end else begin
            // new group joins the back of the ring
            grp_wdata.depth = gfls_pkg::DEPTH_W'(1);
            ring_we         = 1'b1;
            ring_tail_next  = ring_step(ring_tail);
            ring_fill_next  = ring_fill + gfls_pkg::FILL_W'(1);
          end
        end
      end
      gfls_pkg::S_POP_GRP: begin
        grp_raddr = ring_rdata;
      end
      gfls_pkg::S_POP_TOP: begin
        id_raddr = grp_rdata.top;
      end
      gfls_pkg::S_POP_LINK: begin
        res_load         = 1'b1;
        res_status_next  = gfls_pkg::ST_POPPED;
        res_id_next      = gfls_pkg::ID_W'(pop_top) + gfls_pkg::ID_W'(1);
        id_we            = 1'b1;
        id_waddr         = pop_top;
        id_wdata.present = 1'b0;
        id_wdata.link    = id_rdata.link;
        grp_we           = 1'b1;
        grp_waddr        = pop_grp;
        if (pop_depth <= gfls_pkg::DEPTH_W'(1)) begin
          // stack emptied, group leaves the ring
          grp_wdata.active = 1'b0;
          grp_wdata.top    = pop_top;
          grp_wdata.depth  = '0;
          ring_head_next   = ring_step(ring_head);
          ring_fill_next   = ring_fill - gfls_pkg::FILL_W'(1);
        end else begin
          grp_wdata.active = 1'b1;
          grp_wdata.top    = id_rdata.link;
          grp_wdata.depth  = pop_depth - gfls_pkg::DEPTH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gfls_pkg::S_CLEAR;
      clr_cnt   <= '0;
      ring_head <= '0;
      ring_tail <= '0;
      ring_fill <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ring_head <= ring_head_next;
      ring_tail <= ring_tail_next;
      ring_fill <= ring_fill_next;
      if (state == gfls_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + gfls_pkg::CLR_W'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_ok <= id_ok && grp_ok;
      ix      <= id_dec[gfls_pkg::IX_W-1:0];
      grp     <= request.item_group[gfls_pkg::GR_W-1:0];
    end
    if (state == gfls_pkg::S_POP_GRP) begin
      pop_grp <= ring_rdata;
    end
    if (state == gfls_pkg::S_POP_TOP) begin
      pop_top   <= grp_rdata.top;
      pop_depth <= grp_rdata.depth;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_id     <= res_id_next;
    end
  end

endmodule
